// ===== rtl/core/ats_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants of the animation timeline stepper.
// ----------------------------------------------------------------------------
package ats_pkg;

	localparam int TIME_BITS = 48;
	localparam int FRAC_BITS = 16;
	localparam int PROG_BITS = FRAC_BITS + 1;
	localparam int DUR_BITS  = 24;
	localparam int REP_BITS  = 16;
	localparam int KIND_BITS = 2;
	localparam int IDX_BITS  = 3;
	localparam int CNT_BITS  = $clog2(FRAC_BITS);

	localparam logic [PROG_BITS-1:0] ONE_Q = PROG_BITS'(1) << FRAC_BITS;

	// request kinds
	typedef enum logic [KIND_BITS-1:0] {
		KIND_FRAME  = 2'd0,
		KIND_START  = 2'd1,
		KIND_CANCEL = 2'd2
	} kind_t;

	// configuration register indexes
	typedef enum logic [IDX_BITS-1:0] {
		REG_DURATION     = 3'd0,
		REG_START_OFFSET = 3'd1,
		REG_REPEAT_LIMIT = 3'd2,
		REG_REVERSE_MODE = 3'd3,
		REG_FILL_ENABLED = 3'd4,
		REG_FILL_BEFORE  = 3'd5,
		REG_FILL_AFTER   = 3'd6
	} cfg_idx_t;

	// position of a frame relative to the current cycle
	typedef enum logic [1:0] {
		RG_BEFORE,
		RG_INSIDE,
		RG_END,
		RG_AFTER
	} region_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_OFS,
		ST_CMP,
		ST_DIV,
		ST_FIN
	} state_t;

	// one result item
	typedef struct packed {
		logic                 applied;
		logic [PROG_BITS-1:0] progress;
		logic                 fired_start;
		logic                 fired_repeat;
		logic                 fired_end;
		logic                 more;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/ats_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ats_if
// Request, response and configuration channels of the timeline stepper.
// ----------------------------------------------------------------------------
interface ats_req_if;
	import ats_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [KIND_BITS-1:0] kind;
	logic [TIME_BITS-1:0] time_ms;
	logic                 anchor_on_first_frame;
	modport source(output valid, kind, time_ms, anchor_on_first_frame, input ready);
	modport sink(input valid, kind, time_ms, anchor_on_first_frame, output ready);
endinterface

interface ats_rsp_if;
	import ats_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 applied;
	logic [PROG_BITS-1:0] progress;
	logic                 fired_start;
	logic                 fired_repeat;
	logic                 fired_end;
	logic                 more;
	modport source(output valid, applied, progress, fired_start, fired_repeat, fired_end,
		more, input ready);
	modport sink(input valid, applied, progress, fired_start, fired_repeat, fired_end,
		more, output ready);
endinterface

interface ats_cfg_if;
	import ats_pkg::*;
	logic                valid;
	logic                ready;
	logic [IDX_BITS-1:0] index;
	logic [DUR_BITS-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/animation_timeline_stepper_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// animation_timeline_stepper_core
// Timing core of a view animation: start offset, repeat, reverse and fill.
// Frame requests inside a cycle pass through SUB, OFS, CMP, DIV and FIN; the
// restoring divider in DIV (one quotient bit a cycle) forms the 16-bit fraction.
// Other frames skip DIV, and start and cancel requests go straight to FIN.
// A new request is taken once the sequencer is back in idle, even while the
// last result waits in the output register. Reset loads the flag and register
// reset values at once; no clearing pass.
// ----------------------------------------------------------------------------
module animation_timeline_stepper_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ats_req_if.sink    req,
	ats_rsp_if.source  rsp,
	ats_cfg_if.sink    cfg
);
	import ats_pkg::*;

	// configuration registers
	logic [DUR_BITS-1:0]        dur_q;
	logic [DUR_BITS-1:0]        ofs_q;
	logic signed [REP_BITS-1:0] rep_limit_q;
	logic                       reverse_q;
	logic                       fill_en_q;
	logic                       fill_before_q;
	logic                       fill_after_q;

	// animation state
	logic [TIME_BITS-1:0] anchor_q;
	logic                 pending_q;
	logic                 canceled_q;
	logic                 started_q;
	logic                 ended_q;
	logic                 flip_q;
	logic [REP_BITS-1:0]  repeats_q;
	logic                 extra_q;

	// sequencer and datapath
	state_t               state_q, state_d;
	logic [KIND_BITS-1:0] kind_q;
	logic [TIME_BITS-1:0] t_q;
	logic                 anchor_next_q;
	logic [TIME_BITS-1:0] diff_q;
	logic                 lt_q;
	logic                 before_q;
	logic [TIME_BITS-1:0] el_q;
	region_t              region_q;
	logic [DUR_BITS-1:0]  rem_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [CNT_BITS-1:0]  cnt_q;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic req_fire, out_free, fin_load, div_last;

	// shared arithmetic
	logic [TIME_BITS-1:0] anc_eff;
	logic [TIME_BITS:0]   sub_res;
	logic [TIME_BITS:0]   ofs_res;
	logic                 el_lt_dur, el_eq_dur;
	region_t              region_d;
	logic                 need_div;
	logic [DUR_BITS:0]    rem_sh;
	logic                 rem_ge;
	logic [DUR_BITS:0]    rem_sub;

	// results of the final step
	rsp_t                 rsp_d;
	logic [TIME_BITS-1:0] anchor_n;
	logic                 pending_n, canceled_n, started_n, ended_n, flip_n, extra_n;
	logic [REP_BITS-1:0]  repeats_n;
	logic                 expired, apply, more_n, rep_eq;
	logic [PROG_BITS-1:0] pos;

	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fin_load  = (state_q == ST_FIN) && out_free;
	assign div_last  = cnt_q == CNT_BITS'(FRAC_BITS - 1);
	assign req.ready = state_q == ST_IDLE;
	assign cfg.ready = 1'b1;

	// anchor in effect for this frame and time since it
	assign anc_eff = (pending_q && !canceled_q) ? t_q : anchor_q;
	assign sub_res = {1'b0, t_q} - {1'b0, anc_eff};
	assign ofs_res = {1'b0, diff_q} - {{(TIME_BITS - DUR_BITS + 1){1'b0}}, ofs_q};

	// elapsed against duration
	assign el_lt_dur = (el_q[TIME_BITS-1:DUR_BITS] == '0) && (el_q[DUR_BITS-1:0] < dur_q);
	assign el_eq_dur = (el_q[TIME_BITS-1:DUR_BITS] == '0) && (el_q[DUR_BITS-1:0] == dur_q);

	// region of the frame
	always_comb begin
		priority if (dur_q == '0) begin
			region_d = (!canceled_q && lt_q) ? RG_INSIDE : RG_END;
		end else if (canceled_q) begin
			region_d = RG_AFTER;
		end else if (before_q) begin
			region_d = RG_BEFORE;
		end else if (el_lt_dur) begin
			region_d = RG_INSIDE;
		end else if (el_eq_dur) begin
			region_d = RG_END;
		end else begin
			region_d = RG_AFTER;
		end
	end

	assign need_div = (dur_q != '0) && !canceled_q && (region_d == RG_INSIDE);

	// one restoring division step
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_ge  = rem_sh >= {1'b0, dur_q};
	assign rem_sub = rem_sh - {1'b0, dur_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.kind == KIND_FRAME) ? ST_SUB : ST_FIN;
				end
			end
			ST_SUB: state_d = ST_OFS;
			ST_OFS: state_d = ST_CMP;
			ST_CMP: state_d = need_div ? ST_DIV : ST_FIN;
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result and state update of a finished request
	always_comb begin
		rsp_d      = '0;
		anchor_n   = anchor_q;
		pending_n  = pending_q;
		canceled_n = canceled_q;
		started_n  = started_q;
		ended_n    = ended_q;
		flip_n     = flip_q;
		repeats_n  = repeats_q;
		extra_n    = extra_q;
		expired    = 1'b0;
		apply      = 1'b0;
		more_n     = 1'b0;
		pos        = '0;
		rep_eq     = !rep_limit_q[REP_BITS-1] && (repeats_q == rep_limit_q);
		unique case (kind_q)
			KIND_START: begin
				pending_n  = anchor_next_q;
				if (!anchor_next_q) begin
					anchor_n = t_q;
				end
				canceled_n = 1'b0;
				started_n  = 1'b0;
				ended_n    = 1'b0;
				flip_n     = 1'b0;
				repeats_n  = '0;
			end
			KIND_CANCEL: begin
				// only a started animation is marked ended here
				rsp_d.fired_end = started_q && !ended_q;
				ended_n    = ended_q || started_q;
				canceled_n = 1'b1;
				pending_n  = 1'b0;
				extra_n    = 1'b0;
			end
			KIND_FRAME: begin
				if (pending_q && !canceled_q) begin
					anchor_n  = t_q;
					pending_n = 1'b0;
				end
				expired = (region_q == RG_END) || (region_q == RG_AFTER) || canceled_q;
				more_n  = !expired;
				if (fill_en_q) begin
					apply = ((region_q != RG_BEFORE) || fill_before_q) &&
						((region_q != RG_AFTER) || fill_after_q);
				end else begin
					apply = 1'b1;
				end
				// progress with mirroring on a reversed cycle
				if (apply) begin
					if (!started_q) begin
						rsp_d.fired_start = 1'b1;
						started_n         = 1'b1;
					end
					unique case (region_q)
						RG_BEFORE: pos = '0;
						RG_INSIDE: pos = {1'b0, quot_q};
						default:   pos = ONE_Q;
					endcase
					if (flip_q) begin
						pos = ONE_Q - pos;
					end
					rsp_d.applied  = 1'b1;
					rsp_d.progress = pos;
				end
				// end of cycle: finish or start the next one
				if (expired) begin
					if (rep_eq || canceled_q) begin
						if (!ended_q) begin
							ended_n         = 1'b1;
							rsp_d.fired_end = 1'b1;
						end
					end else begin
						if (!rep_limit_q[REP_BITS-1] && (rep_limit_q != '0)) begin
							repeats_n = repeats_q + REP_BITS'(1);
						end
						if (reverse_q) begin
							flip_n = !flip_q;
						end
						pending_n          = 1'b1;
						more_n             = 1'b1;
						rsp_d.fired_repeat = 1'b1;
					end
				end
				// one extra frame after the end
				if (!more_n && extra_q) begin
					extra_n    = 1'b0;
					rsp_d.more = 1'b1;
				end else begin
					rsp_d.more = more_n;
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// sequencer, state flags and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			anchor_q    <= '0;
			pending_q   <= 1'b1;
			canceled_q  <= 1'b0;
			started_q   <= 1'b0;
			ended_q     <= 1'b0;
			flip_q      <= 1'b0;
			repeats_q   <= '0;
			extra_q     <= 1'b1;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (fin_load) begin
				rsp_valid_q <= 1'b1;
				anchor_q    <= anchor_n;
				pending_q   <= pending_n;
				canceled_q  <= canceled_n;
				started_q   <= started_n;
				ended_q     <= ended_n;
				flip_q      <= flip_n;
				repeats_q   <= repeats_n;
				extra_q     <= extra_n;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == ST_CMP) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q         <= '0;
			ofs_q         <= '0;
			rep_limit_q   <= '0;
			reverse_q     <= 1'b0;
			fill_en_q     <= 1'b0;
			fill_before_q <= 1'b1;
			fill_after_q  <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_DURATION:     dur_q         <= cfg.data;
				REG_START_OFFSET: ofs_q         <= cfg.data;
				REG_REPEAT_LIMIT: rep_limit_q   <= cfg.data[REP_BITS-1:0];
				REG_REVERSE_MODE: reverse_q     <= cfg.data[0];
				REG_FILL_ENABLED: fill_en_q     <= cfg.data[0];
				REG_FILL_BEFORE:  fill_before_q <= cfg.data[0];
				REG_FILL_AFTER:   fill_after_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// request capture and datapath registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q        <= req.kind;
			t_q           <= req.time_ms;
			anchor_next_q <= req.anchor_on_first_frame;
		end
		if (state_q == ST_SUB) begin
			diff_q <= sub_res[TIME_BITS-1:0];
			lt_q   <= sub_res[TIME_BITS];
		end
		if (state_q == ST_OFS) begin
			el_q     <= ofs_res[TIME_BITS-1:0];
			before_q <= lt_q || ofs_res[TIME_BITS];
		end
		if (state_q == ST_CMP) begin
			region_q <= region_d;
			rem_q    <= el_q[DUR_BITS-1:0];
			quot_q   <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q  <= rem_ge ? rem_sub[DUR_BITS-1:0] : rem_sh[DUR_BITS-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], rem_ge};
		end
		if (fin_load) begin
			rsp_q <= rsp_d;
		end
	end

	// response port
	assign rsp.valid        = rsp_valid_q;
	assign rsp.applied      = rsp_q.applied;
	assign rsp.progress     = rsp_q.progress;
	assign rsp.fired_start  = rsp_q.fired_start;
	assign rsp.fired_repeat = rsp_q.fired_repeat;
	assign rsp.fired_end    = rsp_q.fired_end;
	assign rsp.more         = rsp_q.more;

endmodule
`default_nettype wire

// ===== rtl/core/ats_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ats_checker
// Port-level checks of the timeline stepper, bound to the stepper core.
// ----------------------------------------------------------------------------
module ats_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic                          rsp_applied,
	input wire logic [ats_pkg::PROG_BITS-1:0] rsp_progress,
	input wire logic                          rsp_fired_end,
	input wire logic                          rsp_more
);
	import ats_pkg::*;

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_progress) &&
		$stable(rsp_applied) && $stable(rsp_fired_end) && $stable(rsp_more))
		else $error("response changed while stalled");

	// progress is zero unless applied
	a_prog_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_applied |-> rsp_progress == '0)
		else $error("progress set on a frame that is not applied");

	// progress never passes one
	a_prog_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_progress <= ONE_Q)
		else $error("progress above one");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

endmodule

bind animation_timeline_stepper_core ats_checker u_ats_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_applied   (rsp.applied),
	.rsp_progress  (rsp.progress),
	.rsp_fired_end (rsp.fired_end),
	.rsp_more      (rsp.more)
);
`default_nettype wire

// ===== verif/animation_timeline_stepper_checker.sv =====
// ----------------------------------------------------------------------------
// animation_timeline_stepper_checker
// Watches the request, response and configuration channels of the stepper,
// keeps its own copy of the timeline state and configuration, predicts the
// response to every accepted request and compares it as a whole with the
// response the core returns.
// ----------------------------------------------------------------------------
module animation_timeline_stepper_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	ats_req_if        req,
	ats_rsp_if        rsp,
	ats_cfg_if        cfg,
	output int        mismatches,
	output int        outstanding
);
	import ats_pkg::*;

	// shadow configuration
	logic [DUR_BITS-1:0]        m_duration;
	logic [DUR_BITS-1:0]        m_offset;
	logic signed [REP_BITS-1:0] m_repeat_lim;
	logic                       m_reverse;
	logic                       m_fill_en;
	logic                       m_fill_before;
	logic                       m_fill_after;

	// shadow timeline state
	logic [TIME_BITS-1:0] anchor;
	logic                 anchor_wait;
	logic                 canceled;
	logic                 started;
	logic                 ended;
	logic                 flipped;
	logic [REP_BITS-1:0]  repeats;
	logic                 more_hold;
	logic                 extra_frame;

	// responses still owed by the core, oldest first
	rsp_t progress_due[$];

	// advance the timeline by one request and return the response it causes
	function automatic rsp_t advance_timeline(input logic [KIND_BITS-1:0] kind,
			input logic [TIME_BITS-1:0] t, input logic anchor_next);
		rsp_t                          r;
		region_t                       where;
		logic [TIME_BITS-1:0]          el;
		logic [TIME_BITS+FRAC_BITS-1:0] num;
		logic [PROG_BITS-1:0]          frac;
		logic [PROG_BITS-1:0]          pos;
		logic                          expired;
		logic                          apply;
		r = '0;
		frac = '0;
		case (kind)
		KIND_START: begin
			if (anchor_next) begin
				anchor_wait = 1'b1;
			end else begin
				anchor = t;
				anchor_wait = 1'b0;
			end
			canceled = 1'b0;
			started = 1'b0;
			ended = 1'b0;
			flipped = 1'b0;
			repeats = '0;
			more_hold = 1'b1;
		end
		KIND_CANCEL: begin
			if (started && !ended) begin
				r.fired_end = 1'b1;
				ended = 1'b1;
			end
			canceled = 1'b1;
			anchor_wait = 1'b0;
			more_hold = 1'b0;
			extra_frame = 1'b0;
		end
		KIND_FRAME: begin
			// a pending anchor takes the time of this frame
			if (anchor_wait && !canceled) begin
				anchor = t;
				anchor_wait = 1'b0;
			end

			// where the frame falls relative to the cycle
			if (m_duration == '0) begin
				where = (!canceled && t < anchor) ? RG_INSIDE : RG_END;
			end else if (canceled) begin
				where = RG_AFTER;
			end else if (t < anchor || (t - anchor) < TIME_BITS'(m_offset)) begin
				where = RG_BEFORE;
			end else begin
				el = t - anchor - TIME_BITS'(m_offset);
				if (el < TIME_BITS'(m_duration)) begin
					where = RG_INSIDE;
					num = {el, FRAC_BITS'(0)};
					frac = PROG_BITS'(num / (TIME_BITS+FRAC_BITS)'(m_duration));
				end else if (el == TIME_BITS'(m_duration)) begin
					where = RG_END;
				end else begin
					where = RG_AFTER;
				end
			end

			expired = where == RG_END || where == RG_AFTER || canceled;
			more_hold = !expired;

			// fill rules
			if (m_fill_en)
				apply = (where != RG_BEFORE || m_fill_before) &&
					(where != RG_AFTER || m_fill_after);
			else
				apply = 1'b1;

			if (apply) begin
				if (!started) begin
					r.fired_start = 1'b1;
					started = 1'b1;
				end
				case (where)
				RG_BEFORE: pos = '0;
				RG_INSIDE: pos = frac;
				default:   pos = ONE_Q;
				endcase
				if (flipped)
					pos = ONE_Q - pos;
				r.applied = 1'b1;
				r.progress = pos;
			end

			// end of cycle: finish or start the next repeat
			if (expired) begin
				if (int'(repeats) == int'(m_repeat_lim) || canceled) begin
					if (!ended) begin
						ended = 1'b1;
						r.fired_end = 1'b1;
					end
				end else begin
					if (m_repeat_lim > 0)
						repeats = repeats + 1'b1;
					if (m_reverse)
						flipped = !flipped;
					anchor_wait = 1'b1;
					more_hold = 1'b1;
					r.fired_repeat = 1'b1;
				end
			end

			// one extra true after the animation is done
			if (!more_hold && extra_frame) begin
				extra_frame = 1'b0;
				r.more = 1'b1;
			end else begin
				r.more = more_hold;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic report(input string what, input rsp_t want, input rsp_t got);
		mismatches = mismatches + 1;
		if (mismatches <= 10)
			$display("%0t %s: expected applied=%0b progress=%0d start=%0b repeat=%0b end=%0b more=%0b",
				$time, what, want.applied, want.progress, want.fired_start,
				want.fired_repeat, want.fired_end, want.more,
				"\n    got applied=%0b progress=%0d start=%0b repeat=%0b end=%0b more=%0b",
				got.applied, got.progress, got.fired_start, got.fired_repeat,
				got.fired_end, got.more);
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			m_duration = '0;
			m_offset = '0;
			m_repeat_lim = '0;
			m_reverse = 1'b0;
			m_fill_en = 1'b0;
			m_fill_before = 1'b1;
			m_fill_after = 1'b0;
			anchor = '0;
			anchor_wait = 1'b1;
			canceled = 1'b0;
			started = 1'b0;
			ended = 1'b0;
			flipped = 1'b0;
			repeats = '0;
			more_hold = 1'b1;
			extra_frame = 1'b1;
			progress_due.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// responses first: they always belong to earlier requests
			if (rsp.valid && rsp.ready) begin
				got = {rsp.applied, rsp.progress, rsp.fired_start, rsp.fired_repeat,
					rsp.fired_end, rsp.more};
				if (progress_due.size() == 0) begin
					report("response with no request pending", '0, got);
				end else begin
					want = progress_due.pop_front();
					if (want !== got)
						report("response mismatch", want, got);
				end
			end

			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_DURATION:     m_duration = cfg.data;
				REG_START_OFFSET: m_offset = cfg.data;
				REG_REPEAT_LIMIT: m_repeat_lim = cfg.data[REP_BITS-1:0];
				REG_REVERSE_MODE: m_reverse = cfg.data[0];
				REG_FILL_ENABLED: m_fill_en = cfg.data[0];
				REG_FILL_BEFORE:  m_fill_before = cfg.data[0];
				REG_FILL_AFTER:   m_fill_after = cfg.data[0];
				default: ;
				endcase
			end

			// requests
			if (req.valid && req.ready)
				progress_due.push_back(advance_timeline(req.kind, req.time_ms,
					req.anchor_on_first_frame));

			outstanding <= progress_due.size();
		end
	end

endmodule

// ===== verif/animation_timeline_stepper_core_tb.sv =====
// ----------------------------------------------------------------------------
// animation_timeline_stepper_core_tb
// Drives frame, start and cancel requests into the timeline stepper under
// changing configurations, with random gaps on the request side and random
// stalls on the response side, and leaves the checking to the checker.
// ----------------------------------------------------------------------------
module animation_timeline_stepper_core_tb;
	import ats_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int QUIET_AFTER  = 340;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
	localparam logic [IDX_BITS-1:0]  REG_UNUSED  = 3'd7;
	localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quiet = 1'b0;
	logic hold_go = 1'b0;
	logic holding = 1'b0;
	int   errors;
	int   outstanding;
	int   sent = 0;
	int   cycles = 0;

	logic [TIME_BITS-1:0] now = '0;
	logic [DUR_BITS-1:0]  cur_dur = '0;
	logic [DUR_BITS-1:0]  cur_ofs = '0;

	ats_req_if req();
	ats_rsp_if rsp();
	ats_cfg_if cfg();

	animation_timeline_stepper_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	animation_timeline_stepper_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.mismatches  (errors),
		.outstanding (outstanding)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// response side: random stall bursts, one long hold-off
	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_go) begin
				hold_go = 1'b0;
				holding = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// one request, after an optional idle burst
	task automatic post(input logic [KIND_BITS-1:0] kind, input logic [TIME_BITS-1:0] t,
			input logic afn);
		if (!quiet && !holding && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.time_ms <= t;
		req.anchor_on_first_frame <= afn;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (kind != KIND_UNUSED)
			sent++;
	endtask

	// stop requests and wait until every response is back
	task automatic settle();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [DUR_BITS-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == REG_DURATION)
			cur_dur = data;
		if (idx == REG_START_OFFSET)
			cur_ofs = data;
	endtask

	// random register value, extremes favored; upper bits of narrow registers stay random
	function automatic logic [DUR_BITS-1:0] pick_setting(input logic [IDX_BITS-1:0] idx);
		logic [DUR_BITS-1:0] v;
		v = DUR_BITS'($urandom);
		case (idx)
		REG_DURATION: begin
			case ($urandom_range(0, 5))
			0: v = '0;
			1: v = DUR_BITS'(1);
			2: v = '1;
			3: v = DUR_BITS'($urandom_range(2, 100));
			4: v = DUR_BITS'($urandom_range(100, 5000));
			default: ;
			endcase
		end
		REG_START_OFFSET: begin
			case ($urandom_range(0, 5))
			0, 1: v = '0;
			2: v = '1;
			3: v = DUR_BITS'($urandom_range(1, 200));
			4: v = DUR_BITS'($urandom_range(200, 3000));
			default: ;
			endcase
		end
		REG_REPEAT_LIMIT: begin
			case ($urandom_range(0, 6))
			0: v[REP_BITS-1:0] = 16'hFFFF;
			1: v[REP_BITS-1:0] = '0;
			2, 3: v[REP_BITS-1:0] = REP_BITS'($urandom_range(1, 4));
			4: v[REP_BITS-1:0] = 16'h7FFF;
			5: v[REP_BITS-1:0] = 16'h8000;
			default: ;
			endcase
		end
		default: ;
		endcase
		return v;
	endfunction

	// next frame distance, aimed at the cycle edges of the current setting
	function automatic logic [TIME_BITS-1:0] pick_step();
		logic [TIME_BITS-1:0] span;
		span = TIME_BITS'(cur_dur) + TIME_BITS'(cur_ofs);
		case ($urandom_range(0, 9))
		0: return '0;
		1: return TIME_BITS'(1);
		2: return TIME_BITS'(cur_ofs);
		3: return span;
		4: return span + 1'b1;
		5: return span - 1'b1;
		6: return TIME_BITS'($urandom) % (span + 1'b1);
		7: return TIME_BITS'(cur_ofs) + TIME_BITS'($urandom) % (TIME_BITS'(cur_dur) + 1'b1);
		8: return TIME_BITS'($urandom);
		default: return TIME_BITS'($urandom_range(1, 1000));
		endcase
	endfunction

	// stimulus
	initial begin : stimulus
		int   rand_base;
		int   n;
		int   r;
		logic first;
		logic hold_done;
		req.valid <= 1'b0;
		req.kind <= KIND_FRAME;
		req.time_ms <= '0;
		req.anchor_on_first_frame <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_DURATION;
		cfg.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, zero duration: pending anchor, step to the end, extra more
		post(KIND_FRAME, '0, 1'b1);
		post(KIND_FRAME, TIME_MAX, 1'b0);
		post(KIND_UNUSED, TIME_MAX, 1'b1);
		post(KIND_CANCEL, '0, 1'b0);
		post(KIND_FRAME, TIME_BITS'(5), 1'b0);
		post(KIND_START, TIME_BITS'(1000), 1'b0);
		post(KIND_FRAME, TIME_BITS'(999), 1'b1);

		// reversed repeats, no fill on either side
		settle();
		write_reg(REG_DURATION, DUR_BITS'(1000));
		write_reg(REG_START_OFFSET, DUR_BITS'(100));
		write_reg(REG_REPEAT_LIMIT, DUR_BITS'(2));
		write_reg(REG_REVERSE_MODE, DUR_BITS'(1));
		write_reg(REG_FILL_ENABLED, DUR_BITS'(1));
		write_reg(REG_FILL_BEFORE, '0);
		write_reg(REG_FILL_AFTER, '0);
		write_reg(REG_UNUSED, '1);
		cfg.valid <= 1'b0;
		post(KIND_START, TIME_MAX, 1'b1);
		post(KIND_FRAME, TIME_BITS'(50000), 1'b0);
		post(KIND_FRAME, TIME_BITS'(50600), 1'b1);
		post(KIND_FRAME, TIME_BITS'(51100), 1'b0);
		post(KIND_FRAME, TIME_BITS'(60000), 1'b0);
		post(KIND_FRAME, TIME_BITS'(61100), 1'b0);
		post(KIND_FRAME, TIME_BITS'(70000), 1'b0);
		post(KIND_FRAME, TIME_BITS'(80000), 1'b0);

		// longest cycle, repeat forever, fill both sides, cancel mid-run
		settle();
		write_reg(REG_DURATION, '1);
		write_reg(REG_START_OFFSET, '0);
		write_reg(REG_REPEAT_LIMIT, DUR_BITS'(16'hFFFF));
		write_reg(REG_REVERSE_MODE, '0);
		write_reg(REG_FILL_BEFORE, DUR_BITS'(1));
		write_reg(REG_FILL_AFTER, DUR_BITS'(1));
		cfg.valid <= 1'b0;
		post(KIND_START, '0, 1'b0);
		post(KIND_FRAME, TIME_MAX, 1'b0);
		post(KIND_FRAME, TIME_BITS'(5), 1'b0);
		post(KIND_CANCEL, '0, 1'b1);
		post(KIND_FRAME, TIME_BITS'(100), 1'b0);

		// repeat count left above a lowered limit keeps counting
		settle();
		write_reg(REG_DURATION, DUR_BITS'(1));
		write_reg(REG_REPEAT_LIMIT, DUR_BITS'(3));
		write_reg(REG_FILL_ENABLED, '0);
		cfg.valid <= 1'b0;
		post(KIND_START, '0, 1'b0);
		post(KIND_FRAME, TIME_BITS'(1), 1'b0);
		post(KIND_FRAME, TIME_BITS'(2), 1'b0);
		post(KIND_FRAME, TIME_BITS'(3), 1'b0);
		settle();
		write_reg(REG_REPEAT_LIMIT, DUR_BITS'(1));
		cfg.valid <= 1'b0;
		post(KIND_FRAME, TIME_BITS'(4), 1'b0);
		post(KIND_FRAME, TIME_BITS'(5), 1'b0);
		now = TIME_BITS'(100);

		// random phases: new settings, then a mostly well-formed request sequence
		rand_base = sent;
		first = 1'b1;
		hold_done = 1'b0;
		while (sent < rand_base + RANDOM_ITEMS) begin
			settle();
			quiet = (sent - rand_base) > QUIET_AFTER;
			for (int i = REG_DURATION; i <= REG_FILL_AFTER; i++)
				if (first || $urandom_range(0, 1) == 1)
					write_reg(IDX_BITS'(i), pick_setting(IDX_BITS'(i)));
			if ($urandom_range(0, 15) == 0)
				write_reg(REG_UNUSED, DUR_BITS'($urandom));
			cfg.valid <= 1'b0;
			first = 1'b0;

			// long response hold-off while requests keep coming
			n = $urandom_range(3, 14);
			if (!hold_done && sent - rand_base >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_go = 1'b1;
				n = 12;
			end

			// how the sequence starts
			case ($urandom_range(0, 5))
			0, 1: post(KIND_START, now, 1'b0);
			2: post(KIND_START, TIME_BITS'({$urandom, $urandom}), 1'b1);
			3: begin
				case ($urandom_range(0, 2))
				0: now = TIME_MAX - TIME_BITS'($urandom_range(0, 3000));
				1: now = '0;
				default: now = TIME_BITS'({$urandom, $urandom});
				endcase
				post(KIND_START, now, 1'b0);
			end
			default: ;
			endcase

			// frames with random content, some noise and broken sequences
			repeat (n) begin
				r = $urandom_range(0, 31);
				if (r == 0) begin
					post(KIND_CANCEL, TIME_BITS'($urandom), 1'($urandom));
				end else if (r == 1) begin
					post(KIND_UNUSED, TIME_BITS'({$urandom, $urandom}), 1'($urandom));
				end else if (r == 2) begin
					post(KIND_START, now, 1'($urandom));
				end else if (r == 3) begin
					post(KIND_FRAME, TIME_BITS'({$urandom, $urandom}), 1'($urandom));
				end else begin
					now = now + pick_step();
					post(KIND_FRAME, now, 1'($urandom));
				end
			end
		end

		// drain and verdict
		quiet = 1'b1;
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
